>>> rtl/core/rrt_pkg.sv
// Package for the tree extender: operation and status codes, configuration register addresses, field widths.
// Used by rrt_tree_extender; no dependencies.
package rrt_pkg;

  localparam int unsigned MaxVerticesDefault = 1024;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned StepW    = 14;
  localparam int unsigned BudgetW  = 10;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [1:0] OpRestart = 2'd0;
  localparam logic [1:0] OpExtend  = 2'd1;

  localparam logic [StatusW-1:0] StAdded    = 3'd0;
  localparam logic [StatusW-1:0] StGoal     = 3'd1;
  localparam logic [StatusW-1:0] StDone     = 3'd2;
  localparam logic [StatusW-1:0] StBudget   = 3'd3;
  localparam logic [StatusW-1:0] StRead     = 3'd4;
  localparam logic [StatusW-1:0] StRestart  = 3'd5;
  localparam logic [StatusW-1:0] StBadIndex = 3'd6;

  localparam logic [CfgAddrW-1:0] RegStartX = 3'd0;
  localparam logic [CfgAddrW-1:0] RegStartY = 3'd1;
  localparam logic [CfgAddrW-1:0] RegGoalX  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegGoalY  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegStep   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegRadius = 3'd5;
  localparam logic [CfgAddrW-1:0] RegBudget = 3'd6;

endpackage

>>> rtl/core/rrt_tree_extender.sv
// Top level of the tree extender: vertex memory, nearest-vertex scan,
// iterative square root and divider for steering. Depends on rrt_pkg.
//
// Channel  Dir  Payload
// in_      in   tuser operation; tdata {read_index, sample_y, sample_x}
// out_     out  tuser status; tdata {parent, y, x, index}, tlast
// cfg_     in   addr (register index), data
//
// An extend that steers does one memory read per vertex during the scan, an
// iterative square root and two divides. Without steering it skips the root
// and the divides; a goal vertex adds a second result. Reset clears control
// state and loads the configuration defaults; memory contents are undefined
// until written. A stalled result holds the block until it is taken; the
// input is taken only while the block is idle.
module rrt_tree_extender #(
  parameter int unsigned MAX_VERTICES = rrt_pkg::MaxVerticesDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // bits: operation[1:0]
  input  logic [1:0]                        in_tuser,
  // bits: sample_x[15:0], sample_y[31:16], read_index[41:32]
  input  logic [47:0]                       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // bits: status[2:0]
  output logic [2:0]                        out_tuser,
  // bits: vertex_index[9:0], vertex_x[25:10], vertex_y[41:26],
  // parent_index[51:42]
  output logic [55:0]                       out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrt_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [15:0]                       cfg_data
);
  import rrt_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_SCAN, S_SQRT, S_DIVX, S_DIVY, S_STORE, S_GOAL, S_OUT
  } state_t;

  // Configuration registers.
  logic signed [CoordW-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [StepW-1:0]   step_r, radius_r;
  logic [BudgetW-1:0] budget_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0; start_y_r <= '0;
      goal_x_r <= 16'sd2560; goal_y_r <= 16'sd2560;
      step_r <= 14'd512; radius_r <= 14'd512; budget_r <= 10'd1022;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        RegStartX: start_x_r <= cfg_data;
        RegStartY: start_y_r <= cfg_data;
        RegGoalX:  goal_x_r  <= cfg_data;
        RegGoalY:  goal_y_r  <= cfg_data;
        RegStep:   step_r    <= cfg_data[StepW-1:0];
        RegRadius: radius_r  <= cfg_data[StepW-1:0];
        RegBudget: budget_r  <= cfg_data[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  // Vertex memory: x, y and parent in one word.
  logic [2*CoordW+AW-1:0] mem [MAX_VERTICES];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [2*CoordW+AW-1:0] mem_wd, mem_rd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end
  logic signed [CoordW-1:0] rd_x, rd_y;
  logic [AW-1:0]            rd_par;
  assign rd_x   = mem_rd[CoordW-1:0];
  assign rd_y   = mem_rd[2*CoordW-1:CoordW];
  assign rd_par = mem_rd[2*CoordW+AW-1:2*CoordW];

  // Control and datapath registers.
  state_t state_r;
  logic [CW-1:0]      count_r;
  logic [BudgetW-1:0] taken_r;
  logic               goal_r;
  logic signed [CoordW-1:0] sx_r, sy_r;
  logic [IndexW-1:0]  ridx_r;
  logic [CW-1:0]      scan_r;   // address in flight
  logic [AW-1:0]      scan_idx_r;
  logic [33:0]        best_d2_r;
  logic [AW-1:0]      best_r;
  logic signed [CoordW-1:0] bx_r, by_r;
  logic signed [CoordW-1:0] nx_r, ny_r;
  logic [33:0]        rem_r;    // sqrt remainder
  logic [17:0]        root_r;
  logic [33:0]        sq_n_r;
  logic [5:0]         it_r;
  logic [31:0]        dnum_r;   // divide dividend shifting out
  logic [32:0]        drem_r;
  logic [31:0]        dq_r;
  logic [AW-1:0]      new_idx_r;
  logic               two_r;
  logic               out_v_r, out_last_r;
  logic [StatusW-1:0] o_st_r;
  logic [IndexW-1:0]  o_idx_r, o_par_r;
  logic signed [CoordW-1:0] o_x_r, o_y_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = o_st_r;
  assign out_tdata  = {4'b0, o_par_r, o_y_r, o_x_r, o_idx_r};

  // Scan distance of the read vertex to the sample.
  logic signed [16:0] ddx, ddy;
  logic [33:0]        d2;
  assign ddx = 17'(sx_r) - 17'(rd_x);
  assign ddy = 17'(sy_r) - 17'(rd_y);
  assign d2  = 34'(ddx * ddx) + 34'(ddy * ddy);

  // Steering offset sign and magnitude for the divide phases.
  logic signed [16:0] ox, oy;
  logic [16:0]        mag_x, mag_y;
  assign ox = 17'(sx_r) - 17'(bx_r);
  assign oy = 17'(sy_r) - 17'(by_r);
  assign mag_x = ox[16] ? 17'(-ox) : 17'(ox);
  assign mag_y = oy[16] ? 17'(-oy) : 17'(oy);

  // Goal test on the new vertex.
  logic signed [16:0] gdx, gdy;
  logic [33:0]        gd2;
  assign gdx = 17'(nx_r) - 17'(goal_x_r);
  assign gdy = 17'(ny_r) - 17'(goal_y_r);
  assign gd2 = 34'(gdx * gdx) + 34'(gdy * gdy);

  // One restoring step each for sqrt and divide.
  logic [33:0] sq_trial;
  logic [32:0] d_sh, d_div;
  assign sq_trial = {rem_r[31:0], sq_n_r[33:32]} - {14'd0, root_r, 2'b01};
  assign d_sh     = {drem_r[31:0], dnum_r[31]};
  assign d_div    = {14'd0, root_r, 1'b0};

  logic signed [CoordW-1:0] rounded;
  always_comb begin
    logic [31:0] q;
    q = dq_r;
    rounded = dnum_r[0] ? CoordW'(-$signed({1'b0, q[15:0]}))
                        : CoordW'($signed({1'b0, q[15:0]}));
  end

  always_comb begin
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
    mem_ra = scan_r[AW-1:0];
    // A read fetches its entry at once; an extend starts the scan at entry zero.
    if (state_r == S_IDLE) mem_ra = in_tuser[1] ? AW'(in_tdata[41:32]) : '0;
    if (state_r == S_STORE) begin
      mem_we = 1'b1; mem_wa = AW'(count_r);
      mem_wd = {best_r, ny_r, nx_r};
    end
    if (state_r == S_GOAL) begin
      mem_we = 1'b1; mem_wa = AW'(new_idx_r + 1'b1);
      mem_wd = {new_idx_r, goal_y_r, goal_x_r};
    end
    if (state_r == S_IDLE && in_tvalid && in_tuser == OpRestart) begin
      mem_we = 1'b1; mem_wa = '0; mem_wd = {{AW{1'b0}}, start_y_r, start_x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; taken_r <= '0; goal_r <= 1'b0;
      out_v_r <= 1'b0; two_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sx_r <= in_tdata[15:0]; sy_r <= in_tdata[31:16];
            ridx_r <= in_tdata[41:32];
            out_last_r <= 1'b1; o_idx_r <= '0; o_x_r <= '0; o_y_r <= '0;
            o_par_r <= '0; two_r <= 1'b0;
            if (in_tuser[1]) begin
              state_r <= S_RDWAIT;
            end else if (in_tuser == OpRestart) begin
              count_r <= CW'(1); taken_r <= '0; goal_r <= 1'b0;
              o_st_r <= StRestart; o_x_r <= start_x_r; o_y_r <= start_y_r;
              out_v_r <= 1'b1; state_r <= S_OUT;
            end else if (count_r == '0 || goal_r) begin
              o_st_r <= StDone; out_v_r <= 1'b1; state_r <= S_OUT;
            end else if (taken_r >= budget_r || count_r >= CW'(MAX_VERTICES)) begin
              o_st_r <= StBudget; out_v_r <= 1'b1; state_r <= S_OUT;
            end else begin
              scan_r <= CW'(1);
              scan_idx_r <= '0; state_r <= S_SCAN;
            end
          end
        end
        S_RDWAIT: begin
          o_idx_r <= ridx_r;
          if (CW'(ridx_r) < count_r) begin
            o_st_r <= StRead; o_x_r <= rd_x; o_y_r <= rd_y;
            o_par_r <= IndexW'(rd_par);
          end else o_st_r <= StBadIndex;
          out_v_r <= 1'b1; state_r <= S_OUT;
        end
        S_SCAN: begin
          // Scan one vertex per cycle; the first minimum wins.
          if (scan_idx_r == '0 || d2 < best_d2_r) begin
            best_d2_r <= d2; best_r <= scan_idx_r; bx_r <= rd_x; by_r <= rd_y;
          end
          scan_idx_r <= AW'(scan_r);
          scan_r <= scan_r + 1'b1;
          if (CW'(scan_idx_r) + 1'b1 >= count_r) begin
            state_r <= S_SQRT; it_r <= '0;
          end
        end
        S_SQRT: begin
          if (it_r == '0) begin
            if (best_d2_r <= 34'(step_r) * 34'(step_r)) begin
              nx_r <= sx_r; ny_r <= sy_r; state_r <= S_STORE;
            end
            sq_n_r <= best_d2_r; rem_r <= '0; root_r <= '0; it_r <= 6'd1;
          end else begin
            if (!sq_trial[33]) begin
              rem_r <= sq_trial; root_r <= {root_r[16:0], 1'b1};
            end else begin
              rem_r <= {rem_r[31:0], sq_n_r[33:32]}; root_r <= {root_r[16:0], 1'b0};
            end
            sq_n_r <= {sq_n_r[31:0], 2'b00};
            if (it_r == 6'd17) begin
              it_r <= '0; state_r <= S_DIVX;
            end else it_r <= it_r + 1'b1;
          end
        end
        S_DIVX, S_DIVY: begin
          // Restoring divide of (2*mag*len + d) by 2*d, one bit a cycle.
          if (it_r == '0) begin
            dnum_r <= 32'(({15'd0, (state_r == S_DIVX) ? mag_x : mag_y} *
                           {18'd0, step_r}) * 2) + 32'(root_r == '0 ? 18'd1 : root_r);
            drem_r <= '0; dq_r <= '0; it_r <= 6'd1;
            if (root_r == '0) root_r <= 18'd1;
          end else if (it_r <= 6'd32) begin
            if (d_sh >= d_div) begin
              drem_r <= d_sh - d_div; dq_r <= {dq_r[30:0], 1'b1};
            end else begin
              drem_r <= d_sh; dq_r <= {dq_r[30:0], 1'b0};
            end
            dnum_r <= {dnum_r[30:0], 1'b0};
            it_r <= it_r + 1'b1;
          end else if (it_r == 6'd33) begin
            // Park the offset sign where the rounding logic picks it up.
            dnum_r[0] <= (state_r == S_DIVX) ? ox[16] : oy[16];
            it_r <= 6'd63;
          end else begin
            if (state_r == S_DIVX) begin
              nx_r <= CoordW'(bx_r + rounded); state_r <= S_DIVY;
            end else begin
              ny_r <= CoordW'(by_r + rounded); state_r <= S_STORE;
            end
            it_r <= '0;
          end
        end
        S_STORE: begin
          new_idx_r <= AW'(count_r);
          o_st_r <= StAdded; o_idx_r <= IndexW'(count_r);
          o_x_r <= nx_r; o_y_r <= ny_r; o_par_r <= IndexW'(best_r);
          count_r <= count_r + 1'b1;
          taken_r <= taken_r + 1'b1;
          if (gd2 <= 34'(radius_r) * 34'(radius_r)) begin
            goal_r <= 1'b1;
            two_r <= (count_r + 1'b1) < CW'(MAX_VERTICES);
          end
          out_last_r <= !((gd2 <= 34'(radius_r) * 34'(radius_r)) &&
                          ((count_r + 1'b1) < CW'(MAX_VERTICES)));
          out_v_r <= 1'b1; state_r <= S_OUT;
        end
        S_GOAL: begin
          count_r <= count_r + 1'b1;
          o_st_r <= StGoal; o_idx_r <= IndexW'(new_idx_r + 1'b1);
          o_x_r <= goal_x_r; o_y_r <= goal_y_r; o_par_r <= IndexW'(new_idx_r);
          out_last_r <= 1'b1; two_r <= 1'b0;
          out_v_r <= 1'b1; state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_v_r <= 1'b0;
            state_r <= two_r ? S_GOAL : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for rrt_tree_extender: directed and random tree
// growth, reads and restarts, checked against an in-bench tree predictor.
// Depends on rrt_pkg and rrt_tree_extender.
module testbench;
  import rrt_pkg::*;

  localparam logic [1:0] OpRead    = 2'd2;
  localparam logic [1:0] OpReadAlt = 2'd3;
  localparam int StoreDepth = 1024;
  localparam int IdleLimit  = 20000;
  localparam int LongHold   = 2500;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [9:0]         ri;
  } sample_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         par;
    logic               last;
  } vertex_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // Fields from bit 0 up: operation.
  logic [1:0] in_tuser;
  // Fields from bit 0 up: sample_x, sample_y, read_index.
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // Fields from bit 0 up: status.
  logic [2:0] out_tuser;
  // Fields from bit 0 up: vertex_index, vertex_x, vertex_y, parent_index.
  logic [55:0] out_tdata;
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [15:0] cfg_data;

  rrt_tree_extender dut (.*);

  // Shadow configuration and tree state.
  logic signed [15:0] sh_start_x, sh_start_y, sh_goal_x, sh_goal_y;
  logic [13:0] sh_step, sh_radius;
  logic [9:0] sh_budget;
  logic signed [15:0] tree_x [StoreDepth];
  logic signed [15:0] tree_y [StoreDepth];
  logic [9:0] tree_par [StoreDepth];
  int tree_count = 0;
  int samples_used = 0;
  bit tree_frozen = 0;

  sample_t pending_q[$];
  vertex_res_t expected_q[$];
  sample_t cur_item;
  int burst_left, gap_left;
  int errors = 0;
  int idle_cycles;
  int hold_req = 0;
  int hold_seen;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Offset of num*len/den rounded to nearest, ties away from zero.
  function automatic longint steer_offset(input longint num, input longint len,
                                          input longint den);
    longint mag, q;
    mag = (num < 0 ? -num : num) * len;
    q = (mag * 2 + den) / (den * 2);
    return num < 0 ? -q : q;
  endfunction

  function automatic void add_result(input logic [2:0] st, input int idx,
                                     input longint x, input longint y,
                                     input int par, input bit last);
    vertex_res_t r;
    r.status = st;
    r.idx = idx[9:0];
    r.x = x[15:0];
    r.y = y[15:0];
    r.par = par[9:0];
    r.last = last;
    expected_q = {expected_q, r};
  endfunction

  // Works out the results of one accepted transaction and updates the tree.
  function automatic void predict_tree(input sample_t it);
    longint sx, sy, vx, vy, nx, ny, dx, dy, len, gx, gy;
    longint unsigned d2, best_d2, d;
    int best, new_idx;
    bit reach;
    if (it.op == OpRestart) begin
      tree_x[0] = sh_start_x;
      tree_y[0] = sh_start_y;
      tree_par[0] = '0;
      tree_count = 1;
      samples_used = 0;
      tree_frozen = 0;
      add_result(StRestart, 0, longint'(sh_start_x), longint'(sh_start_y), 0, 1);
      return;
    end
    if (it.op[1]) begin
      if (it.ri < tree_count)
        add_result(StRead, int'(it.ri), longint'(tree_x[it.ri]),
                   longint'(tree_y[it.ri]), int'(tree_par[it.ri]), 1);
      else
        add_result(StBadIndex, int'(it.ri), 0, 0, 0, 1);
      return;
    end
    if (tree_count == 0 || tree_frozen) begin
      add_result(StDone, 0, 0, 0, 0, 1);
      return;
    end
    if (samples_used >= sh_budget || tree_count >= StoreDepth) begin
      add_result(StBudget, 0, 0, 0, 0, 1);
      return;
    end
    // Nearest vertex; the first minimum wins.
    sx = it.sx;
    sy = it.sy;
    best = 0;
    best_d2 = 0;
    for (int i = 0; i < tree_count; i++) begin
      dx = sx - tree_x[i];
      dy = sy - tree_y[i];
      d2 = dx * dx + dy * dy;
      if (i == 0 || d2 < best_d2) begin
        best_d2 = d2;
        best = i;
      end
    end
    vx = tree_x[best];
    vy = tree_y[best];
    nx = sx;
    ny = sy;
    len = sh_step;
    if (best_d2 > len * len) begin
      d = int_sqrt(best_d2);
      if (d == 0) d = 1;
      nx = vx + steer_offset(sx - vx, len, d);
      ny = vy + steer_offset(sy - vy, len, d);
    end
    new_idx = tree_count;
    tree_x[new_idx] = nx[15:0];
    tree_y[new_idx] = ny[15:0];
    tree_par[new_idx] = best[9:0];
    tree_count++;
    samples_used = (samples_used + 1) & 10'h3FF;
    // Goal test on the new vertex.
    gx = sh_goal_x;
    gy = sh_goal_y;
    reach = ((nx - gx) * (nx - gx) + (ny - gy) * (ny - gy)) <=
            longint'(sh_radius) * longint'(sh_radius);
    if (reach) tree_frozen = 1;
    if (reach && tree_count < StoreDepth) begin
      tree_x[tree_count] = sh_goal_x;
      tree_y[tree_count] = sh_goal_y;
      tree_par[tree_count] = new_idx[9:0];
      add_result(StAdded, new_idx, nx, ny, best, 0);
      add_result(StGoal, tree_count, gx, gy, new_idx, 1);
      tree_count++;
    end else begin
      add_result(StAdded, new_idx, nx, ny, best, 1);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) predict_tree(cur_item);
      if (in_tvalid && !in_tready) begin
        // Hold the offered transaction.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_item = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_item.op;
        in_tdata <= {6'b0, cur_item.ri, cur_item.sy, cur_item.sx};
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on its own pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      hold_seen = hold_req;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LongHold;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: out_tready <= 1'b0;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    vertex_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h", out_tuser, out_tdata));
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tuser !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser,
                                    exp_r.status));
        if (out_tdata[9:0] !== exp_r.idx)
          report_mismatch($sformatf("vertex_index %0d, expected %0d",
                                    out_tdata[9:0], exp_r.idx));
        if (out_tdata[25:10] !== exp_r.x)
          report_mismatch($sformatf("vertex_x %h, expected %h", out_tdata[25:10],
                                    exp_r.x));
        if (out_tdata[41:26] !== exp_r.y)
          report_mismatch($sformatf("vertex_y %h, expected %h", out_tdata[41:26],
                                    exp_r.y));
        if (out_tdata[51:42] !== exp_r.par)
          report_mismatch($sformatf("parent_index %0d, expected %0d",
                                    out_tdata[51:42], exp_r.par));
        if (out_tlast !== exp_r.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, exp_r.last));
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [15:0] data);
    cfg_addr <= addr;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (addr)
      RegStartX: sh_start_x = data;
      RegStartY: sh_start_y = data;
      RegGoalX:  sh_goal_x = data;
      RegGoalY:  sh_goal_y = data;
      RegStep:   sh_step = data[13:0];
      RegRadius: sh_radius = data[13:0];
      RegBudget: sh_budget = data[9:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int stx, input int sty, input int gx, input int gy,
                            input int stp, input int rad, input int bud);
    write_reg(RegStartX, 16'(stx));
    write_reg(RegStartY, 16'(sty));
    write_reg(RegGoalX, 16'(gx));
    write_reg(RegGoalY, 16'(gy));
    write_reg(RegStep, 16'(stp));
    write_reg(RegRadius, 16'(rad));
    write_reg(RegBudget, 16'(bud));
  endtask

  task automatic push_item(input logic [1:0] op, input int sx, input int sy,
                           input int ri);
    sample_t it;
    it.op = op;
    it.sx = 16'(sx);
    it.sy = 16'(sy);
    it.ri = 10'(ri);
    pending_q = {pending_q, it};
  endtask

  // Sender pause: everything sent, every result back, block quiet.
  task automatic drain();
    @(posedge clk);
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly extends near the tree, with reads and the odd restart.
  task automatic random_phase(input int count);
    logic [1:0] op;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) op = OpRestart;
      else if (pick < 18) op = $urandom_range(0, 1) ? OpRead : OpReadAlt;
      else op = OpExtend;
      if ($urandom_range(0, 3) == 0)
        push_item(op, $urandom, $urandom, $urandom);
      else
        push_item(op, $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 40));
    end
  endtask

  // Stimulus and phase control.
  initial begin
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    sh_start_x = 16'sd0;
    sh_start_y = 16'sd0;
    sh_goal_x = 16'sd2560;
    sh_goal_y = 16'sd2560;
    sh_step = 14'd512;
    sh_radius = 14'd512;
    sh_budget = 10'd1022;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty tree, reset configuration, reads, steering and reaching the goal.
    push_item(OpExtend, 16'sd100, 16'sd100, 10'd0);
    push_item(OpRead, 0, 0, 10'd0);
    push_item(OpRestart, 0, 0, 0);
    push_item(OpExtend, 16'sd100, -16'sd50, 0);
    push_item(OpExtend, 16'sh7FFF, 16'sh7FFF, 0);
    push_item(OpExtend, -16'sh8000, -16'sh8000, 0);
    push_item(OpExtend, -16'sh8000, 16'sh7FFF, 0);
    push_item(OpRead, 0, 0, 10'd1);
    push_item(OpReadAlt, 0, 0, 10'd2);
    push_item(OpRead, 0, 0, 10'h3FF);
    for (int k = 0; k < 8; k++) push_item(OpExtend, 16'sd2560, 16'sd2560, 0);
    push_item(OpExtend, 16'sd0, 16'sd0, 0);
    push_item(OpRead, 0, 0, 10'd5);
    drain();

    // Extreme configuration: tiny step, zero radius, small budget.
    set_config(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd1, 16'd0, 16'd1);
    push_item(OpExtend, 0, 0, 0);
    push_item(OpRestart, 0, 0, 0);
    push_item(OpExtend, 16'sh7FFF, 16'sh7FFF, 0);
    push_item(OpExtend, 16'sh7FFF, -16'sh8000, 0);
    push_item(OpRead, 0, 0, 10'd1);
    drain();

    // Large step and radius, with the goal far from the start.
    set_config(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'd8192, 16'd8192, 16'd1022);
    push_item(OpRestart, 0, 0, 0);
    push_item(OpExtend, 16'sh7000, 16'sh7000, 0);
    push_item(OpExtend, -16'sh8000, 0, 0);
    push_item(OpExtend, -16'sh8000, 0, 0);
    push_item(OpRead, 0, 0, 10'd3);
    drain();

    // Random phases under several settings; the second holds off the output.
    for (int ph = 0; ph < 6; ph++) begin
      set_config($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                 $urandom, $urandom, $urandom_range(1, 8192),
                 $urandom_range(0, 600), (ph == 3) ? 5 : $urandom_range(60, 1022));
      push_item(OpRestart, 0, 0, 0);
      random_phase(85);
      if (ph == 1) hold_req++;
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
